/* rtl/core/ppa_pkg.sv */
// Shared types and constants for the prefix-preserving IPv4 anonymizer.
// AES S-box, class table, register indexes, FSM states. No dependencies.
package ppa_pkg;

    localparam logic [2:0] REG_KEY_FIRST  = 3'd0;
    localparam logic [2:0] REG_KEY_SECOND = 3'd1;
    localparam logic [2:0] REG_PAD_FIRST  = 3'd2;
    localparam logic [2:0] REG_PAD_SECOND = 3'd3;
    localparam logic [2:0] REG_KEEP_LEN   = 3'd4;

    localparam logic ACT_SCRAMBLE   = 1'b0;
    localparam logic ACT_UNSCRAMBLE = 1'b1;

    localparam logic [31:0] UNMATCHED = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        action;
        logic [31:0] address;
        logic [5:0]  first_bit;   // lowest index k not processed: loop runs k = 0 .. 31-p
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROUND,
        ST_NEXT,
        ST_CHECK,
        ST_DONE
    } state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Prefix kept by the address class, from the top nibble
    function automatic logic [5:0] class_prefix(input logic [3:0] nib);
        logic [5:0] r;
        case (nib)
            4'd8, 4'd9, 4'd10, 4'd11: r = 6'd2;
            4'd12, 4'd13:             r = 6'd3;
            4'd14:                    r = 6'd4;
            4'd15:                    r = 6'd32;
            default:                  r = 6'd1;
        endcase
        return r;
    endfunction

    // Lowest flip index not processed: 32 - p, with p clamped to 32.
    function automatic logic [5:0] first_skip(input logic [31:0] x,
                                              input logic [5:0] keep_len);
        logic [5:0] c;
        logic [5:0] p;
        c = class_prefix(x[31:28]);
        p = (keep_len > c) ? keep_len : c;
        if (p > 6'd32)
            p = 6'd32;
        return 6'd32 - p;
    endfunction

endpackage

/* rtl/core/ppa_stream_if.sv */
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
interface ppa_stream_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ppa_aes_core.sv */
// Iterative AES-128 encryption, one round per cycle with on-the-fly key schedule.
// Depends on ppa_pkg.
module ppa_aes_core
    import ppa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] block,
    output logic         done,
    output logic         result_bit
);
    // byte i of the state sits at bits [127-8i -: 8]
    logic [127:0] st_reg, rk_reg;
    logic [3:0]   round_reg;
    logic [7:0]   rcon_reg;
    logic         busy_reg, done_reg;
    logic [127:0] sub, mixed, rk_next, st_next;
    logic [31:0]  tw;

    function automatic logic [7:0] byt(input logic [127:0] v, input int i);
        return v[127-8*i -: 8];
    endfunction

    always_comb
    begin
        sub = '0;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                sub[127-8*(i+4*c) -: 8] = sbox(byt(st_reg, i + 4*((c+i) & 3)));
        mixed = sub;
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = byt(sub, 4*c); a1 = byt(sub, 4*c+1);
            a2 = byt(sub, 4*c+2); a3 = byt(sub, 4*c+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            mixed[127-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            mixed[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            mixed[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mixed[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        tw = {sbox(rk_reg[23:16]) ^ rcon_reg, sbox(rk_reg[15:8]),
              sbox(rk_reg[7:0]), sbox(rk_reg[31:24])};
        rk_next[127:96] = rk_reg[127:96] ^ tw;
        rk_next[95:64]  = rk_reg[95:64] ^ rk_next[127:96];
        rk_next[63:32]  = rk_reg[63:32] ^ rk_next[95:64];
        rk_next[31:0]   = rk_reg[31:0] ^ rk_next[63:32];
        st_next = ((round_reg == 4'd10) ? sub : mixed) ^ rk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= 4'd1;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 4'd1;
                if (round_reg == 4'd10)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            st_reg   <= block ^ key;
            rk_reg   <= key;
            rcon_reg <= 8'h01;
        end
        else if (busy_reg)
        begin
            st_reg   <= st_next;
            rk_reg   <= rk_next;
            rcon_reg <= xtime(rcon_reg);
        end
    end

    assign done       = done_reg;
    assign result_bit = st_reg[120];

endmodule

/* rtl/core/ppa_front.sv */
// Front end: accepts items, classifies the prefix length and queues jobs.
// Depends on ppa_pkg and ppa_stream_if.
module ppa_front
    import ppa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ppa_stream_if.sink  in_ch,
    input  logic [5:0]  keep_len,
    input  logic        job_pop,
    output logic        job_valid,
    output job_t        job
);
    localparam int DEPTH = 2;
    job_t      q_reg [DEPTH];
    logic      wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic      push;
    logic [31:0] a;

    assign a = in_ch.data[31:0];
    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign job = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= '{action: in_ch.data[32], address: a,
                               first_bit: first_skip(a, keep_len)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (job_pop && job_valid)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(job_pop && job_valid);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("job queue overflow");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid) else $error("pop from empty job queue");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ch.ready) else $error("accept while full");

endmodule

/* rtl/core/ppa_back.sv */
// Back end: runs scrambles (and unscramble refinement) over the AES core.
// Depends on ppa_pkg, ppa_aes_core and ppa_stream_if.
module ppa_back
    import ppa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_valid,
    input  job_t         job,
    output logic         job_pop,
    input  logic [127:0] key,
    input  logic [127:0] pad,
    input  logic [5:0]   keep_len,
    ppa_stream_if.source out_ch
);
    state_t      state_reg, state_next;
    logic        action_reg;
    logic [31:0] target_reg;   // input address
    logic [31:0] guess_reg;    // address being scrambled
    logic [31:0] flip_reg;
    logic [4:0]  k_reg;        // current flip index
    logic [5:0]  n_reg;        // refinement count
    logic [31:0] out_reg;
    logic        out_valid_reg;
    logic        aes_start, aes_done, aes_bit;
    logic [31:0] padword, w, scr, diff;
    logic [127:0] blk;

    assign padword = {pad[103:96], pad[111:104], pad[119:112], pad[127:120]};
    // w = (x & (~0 << (k+1))) | (padword >> (31-k))
    assign w = (guess_reg & ~((32'd2 << k_reg) - 32'd1)) | (padword >> (5'd31 - k_reg));
    assign blk = {w[7:0], w[15:8], w[23:16], w[31:24], pad[95:0]};
    assign scr = guess_reg ^ flip_reg;
    assign diff = scr ^ target_reg;

    ppa_aes_core u_aes (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (aes_start),
        .key       (key),
        .block     (blk),
        .done      (aes_done),
        .result_bit(aes_bit)
    );

    always_comb
    begin
        state_next = state_reg;
        aes_start  = 1'b0;
        job_pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (job_valid && !out_valid_reg)
                begin
                    job_pop    = 1'b1;
                    state_next = ST_START;
                end
            ST_START:
                if (k_reg == 5'd31 && first_skip(guess_reg, keep_len) == 6'd32)
                    state_next = ST_CHECK;
                else if ({1'b0, k_reg} < first_skip(guess_reg, keep_len))
                begin
                    aes_start  = 1'b1;
                    state_next = ST_ROUND;
                end
                else
                    state_next = ST_CHECK;
            ST_ROUND:
                if (aes_done)
                    state_next = ST_NEXT;
            ST_NEXT:
                state_next = (k_reg == 5'd31) ? ST_CHECK : ST_START;
            ST_CHECK:
                state_next = ST_DONE;
            ST_DONE:
                // unscramble without a match yet: scramble the refined guess
                state_next = (action_reg == ACT_UNSCRAMBLE && !out_valid_reg)
                             ? ST_START : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_CHECK && (action_reg == ACT_SCRAMBLE || diff == 32'd0
                                          || n_reg == 6'd31))
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (job_pop)
                begin
                    action_reg <= job.action;
                    target_reg <= job.address;
                    guess_reg  <= job.address;
                    flip_reg   <= '0;
                    k_reg      <= '0;
                    n_reg      <= '0;
                end
            ST_NEXT:
            begin
                flip_reg[k_reg] <= aes_bit;
                if (k_reg != 5'd31)
                    k_reg <= k_reg + 5'd1;
            end
            ST_CHECK:
                if (action_reg == ACT_SCRAMBLE)
                    out_reg <= scr;
                else if (diff == 32'd0)
                    out_reg <= guess_reg;
                else if (n_reg == 6'd31)
                    out_reg <= UNMATCHED;
            ST_DONE:
                if (action_reg == ACT_UNSCRAMBLE && !out_valid_reg)
                begin
                    guess_reg <= guess_reg ^ diff;
                    flip_reg  <= '0;
                    k_reg     <= '0;
                    n_reg     <= n_reg + 6'd1;
                end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

endmodule

/* rtl/core/ipv4_prefix_preserving_anonymizer.sv */
// channel   dir  payload                      handshake
// in_ch     in   {action, address[31:0]}      valid/ready
// out_ch    out  mapped_address[31:0]         valid/ready
// cfg       in   cfg_we, cfg_index, cfg_data  write on cfg_we
// A scramble runs one 10-round AES per flipped bit (at most 31). An unscramble repeats
// the scramble up to 32 times. The AES core, one round per cycle, sets the rate. Reset
// clears the configuration registers and control state; the result register holds until
// taken while the next item waits in a two-entry job queue.
module ipv4_prefix_preserving_anonymizer
    import ppa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ppa_stream_if.sink   in_ch,
    ppa_stream_if.source out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic [63:0] key_first_reg, key_second_reg, pad_first_reg, pad_second_reg;
    logic [5:0]  keep_len_reg;
    logic        job_valid, job_pop;
    job_t        job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_first_reg  <= '0;
            key_second_reg <= '0;
            pad_first_reg  <= '0;
            pad_second_reg <= '0;
            keep_len_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_FIRST:  key_first_reg  <= cfg_data;
                REG_KEY_SECOND: key_second_reg <= cfg_data;
                REG_PAD_FIRST:  pad_first_reg  <= cfg_data;
                REG_PAD_SECOND: pad_second_reg <= cfg_data;
                REG_KEEP_LEN:   keep_len_reg   <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    ppa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .keep_len (keep_len_reg),
        .job_pop  (job_pop),
        .job_valid(job_valid),
        .job      (job)
    );

    ppa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(job_valid),
        .job      (job),
        .job_pop  (job_pop),
        .key      ({key_first_reg, key_second_reg}),
        .pad      ({pad_first_reg, pad_second_reg}),
        .keep_len (keep_len_reg),
        .out_ch   (out_ch)
    );

endmodule
